// File: rtl/core/cfcf_pkg.sv
// Shared types and constants of the CAN frame change filter.
`timescale 1ns / 1ps
`default_nettype none
package cfcf_pkg;

  localparam int ENTRIES  = 64;
  localparam int CHANNELS = 4;
  localparam int IDX_W    = $clog2(ENTRIES);
  localparam int CNT_W    = $clog2(ENTRIES + 1);

  localparam int CH_W   = 2;
  localparam int ID_W   = 29;
  localparam int LEN_W  = 4;
  localparam int DATA_W = 64;
  localparam int CODE_W = 4;

  localparam logic [LEN_W-1:0] MAX_LEN = 4'd8;

  // signal code bits of payload byte 0
  localparam logic [CODE_W-1:0] SIG_ACTIVE = 4'h8;
  localparam logic [CODE_W-1:0] SIG_BIT2   = 4'h4;
  localparam logic [CODE_W-1:0] SIG_BIT1   = 4'h2;
  localparam logic [CODE_W-1:0] SIG_BIT0   = 4'h1;
  localparam logic [CODE_W-1:0] SIG_MASK   = SIG_ACTIVE | SIG_BIT2 | SIG_BIT1 | SIG_BIT0;

  typedef struct packed {
    logic [CH_W-1:0]   channel;
    logic [ID_W-1:0]   frame_id;
    logic [LEN_W-1:0]  len;
    logic [DATA_W-1:0] data;
  } frame_t;

  typedef struct packed {
    logic hit;   // pair present in the table
    logic same;  // present and length/data unchanged
    logic full;  // no free slot left
  } lookup_t;

  typedef struct packed {
    frame_t            frame;
    logic              first_seen;
    logic [CODE_W-1:0] signal_code;
    logic              signal_valid;
    logic              not_stored;
  } result_t;

endpackage
`default_nettype wire

// File: rtl/core/can_frame_change_filter.sv
// Top level of the CAN frame change filter.
//
//  Channel | Direction | Handshake              | Word
//  --------+-----------+------------------------+-------------------------------------
//  in      | input     | in_valid_i / in_stall_o | channel, frame_id, payload_len, payload
//  out     | output    | out_valid_o / out_stall_i | frame, first_seen, signal, not_stored
//
// One word per cycle while in_stall_o is low. In the input register all 64 slots
// are compared in parallel and the table is updated; the word's report, if any, is
// then loaded into the result register, which drives out_valid_o.
// Reset clears the slot valid bits and the fill count at once; no sweep is needed.
// A stalled output only holds the input register when that word has a report to
// make; words that change nothing still drain.
`timescale 1ns / 1ps
`default_nettype none
module can_frame_change_filter import cfcf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [CH_W-1:0]     channel_i,
  input  logic [ID_W-1:0]     frame_id_i,
  input  logic [LEN_W-1:0]    payload_len_i,
  input  logic [DATA_W-1:0]   payload_i,
  // output channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [CH_W-1:0]     out_channel_o,
  output logic [ID_W-1:0]     out_frame_id_o,
  output logic [LEN_W-1:0]    out_len_o,
  output logic [DATA_W-1:0]   out_payload_o,
  output logic                first_seen_o,
  output logic [CODE_W-1:0]   signal_code_o,
  output logic                signal_valid_o,
  output logic                not_stored_o
);

  logic    s1_valid;
  frame_t  s1_frame;
  lookup_t lookup;
  result_t res_d;
  result_t res_q;
  logic    in_load;
  logic    s1_adv;
  logic    in_range;
  logic    report;
  logic    out_free;
  logic    commit;

  assign in_load = in_valid_i && !in_stall_o;

  cfcf_in_stage u_in (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (in_load),
    .adv_i         (s1_adv),
    .channel_i     (channel_i),
    .frame_id_i    (frame_id_i),
    .payload_len_i (payload_len_i),
    .payload_i     (payload_i),
    .valid_o       (s1_valid),
    .frame_o       (s1_frame)
  );

  cfcf_table u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .frame_i  (s1_frame),
    .commit_i (commit),
    .lookup_o (lookup)
  );

  // frames of channels beyond the configured count are dropped silently
  assign in_range = (32'(s1_frame.channel) < 32'(CHANNELS));

  // unchanged frames produce nothing
  assign report = s1_valid && in_range && !(lookup.hit && lookup.same);

  // the input word moves on when it has no report or the result register is free
  assign s1_adv     = s1_valid && (!report || out_free);
  assign in_stall_o = s1_valid && !s1_adv;
  assign commit     = s1_adv && in_range;

  always_comb begin
    res_d.frame        = s1_frame;
    res_d.first_seen   = !lookup.hit;
    res_d.signal_valid = (s1_frame.len != '0);
    res_d.signal_code  = res_d.signal_valid ? (s1_frame.data[CODE_W-1:0] & SIG_MASK) : '0;
    res_d.not_stored   = !lookup.hit && lookup.full;
  end

  cfcf_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (report && out_free),
    .res_i       (res_d),
    .out_stall_i (out_stall_i),
    .free_o      (out_free),
    .valid_o     (out_valid_o),
    .res_o       (res_q)
  );

  assign out_channel_o  = res_q.frame.channel;
  assign out_frame_id_o = res_q.frame.frame_id;
  assign out_len_o      = res_q.frame.len;
  assign out_payload_o  = res_q.frame.data;
  assign first_seen_o   = res_q.first_seen;
  assign signal_code_o  = res_q.signal_code;
  assign signal_valid_o = res_q.signal_valid;
  assign not_stored_o   = res_q.not_stored;

endmodule
`default_nettype wire

// File: rtl/core/cfcf_in_stage.sv
// Input register with length clamp and unused-byte masking.
`timescale 1ns / 1ps
`default_nettype none
module cfcf_in_stage import cfcf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  logic                adv_i,
  input  logic [CH_W-1:0]     channel_i,
  input  logic [ID_W-1:0]     frame_id_i,
  input  logic [LEN_W-1:0]    payload_len_i,
  input  logic [DATA_W-1:0]   payload_i,
  output logic                valid_o,
  output frame_t              frame_o
);

  logic   valid_q;
  frame_t frame_q;
  frame_t frame_d;
  logic [LEN_W-1:0] len_eff;

  always_comb begin
    len_eff = (payload_len_i > MAX_LEN) ? MAX_LEN : payload_len_i;
    frame_d.channel  = channel_i;
    frame_d.frame_id = frame_id_i;
    frame_d.len      = len_eff;
    for (int b = 0; b < DATA_W / 8; b++) begin
      frame_d.data[b*8 +: 8] = (LEN_W'(b) < len_eff) ? payload_i[b*8 +: 8] : 8'h00;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (adv_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      frame_q <= frame_d;
    end
  end

  assign valid_o = valid_q;
  assign frame_o = frame_q;

endmodule
`default_nettype wire

// File: rtl/core/cfcf_table.sv
// Frame table: per-slot key and data compare, update and fill.
`timescale 1ns / 1ps
`default_nettype none
module cfcf_table import cfcf_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  frame_t  frame_i,
  input  logic    commit_i,
  output lookup_t lookup_o
);

  logic [ENTRIES-1:0] valid_q;
  logic [CH_W-1:0]    ch_q   [ENTRIES];
  logic [ID_W-1:0]    id_q   [ENTRIES];
  logic [LEN_W-1:0]   len_q  [ENTRIES];
  logic [DATA_W-1:0]  data_q [ENTRIES];
  logic [CNT_W-1:0]   fill_q;

  logic [ENTRIES-1:0] key_hit;
  logic [ENTRIES-1:0] data_eq;
  logic [ENTRIES-1:0] wr_en;
  logic               hit, same, full, add;
  logic [IDX_W-1:0]   fill_idx;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      key_hit[i] = valid_q[i] && (ch_q[i] == frame_i.channel) &&
                   (id_q[i] == frame_i.frame_id);
      data_eq[i] = (len_q[i] == frame_i.len) && (data_q[i] == frame_i.data);
    end
    hit      = |key_hit;
    same     = |(key_hit & data_eq);
    full     = (fill_q == CNT_W'(ENTRIES));
    add      = commit_i && !hit && !full;
    fill_idx = fill_q[IDX_W-1:0];
    for (int i = 0; i < ENTRIES; i++) begin
      wr_en[i] = (commit_i && key_hit[i] && !same) ||
                 (add && (fill_idx == IDX_W'(i)));
    end
  end

  // slot contents: written on update or on first use, no reset
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (wr_en[i]) begin
        ch_q[i]   <= frame_i.channel;
        id_q[i]   <= frame_i.frame_id;
        len_q[i]  <= frame_i.len;
        data_q[i] <= frame_i.data;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      fill_q  <= '0;
    end else if (add) begin
      valid_q[fill_idx] <= 1'b1;
      fill_q            <= fill_q + CNT_W'(1);
    end
  end

  assign lookup_o = '{hit: hit, same: same, full: full};

endmodule
`default_nettype wire

// File: rtl/core/cfcf_out_stage.sv
// Result register toward the output channel.
`timescale 1ns / 1ps
`default_nettype none
module cfcf_out_stage import cfcf_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t res_i,
  input  logic    out_stall_i,
  output logic    free_o,
  output logic    valid_o,
  output result_t res_o
);

  logic    valid_q;
  result_t res_q;

  assign free_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule
`default_nettype wire

// File: rtl/core/cfcf_checker.sv
// Port-level checks of the CAN frame change filter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module cfcf_checker import cfcf_pkg::*; (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                out_valid_o,
  input  wire                out_stall_i,
  input  wire [LEN_W-1:0]    out_len_o,
  input  wire [DATA_W-1:0]   out_payload_o,
  input  wire                first_seen_o,
  input  wire [CODE_W-1:0]   signal_code_o,
  input  wire                signal_valid_o,
  input  wire                not_stored_o
);

  // a held report keeps its word
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_payload_o) &&
                                   $stable(out_len_o))
    else $error("report changed while stalled");

  a_not_stored_new: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && not_stored_o |-> first_seen_o)
    else $error("not_stored on a changed frame");

  a_signal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (signal_valid_o == (out_len_o != '0)) &&
                    (signal_valid_o || (signal_code_o == '0)))
    else $error("signal fields disagree with length");

  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_len_o <= MAX_LEN)
    else $error("length above eight");

  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_len_o < MAX_LEN) |->
      ((out_payload_o >> {out_len_o, 3'b000}) == '0))
    else $error("bytes beyond length not zero");

endmodule

bind can_frame_change_filter cfcf_checker u_cfcf_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .out_len_o      (out_len_o),
  .out_payload_o  (out_payload_o),
  .first_seen_o   (first_seen_o),
  .signal_code_o  (signal_code_o),
  .signal_valid_o (signal_valid_o),
  .not_stored_o   (not_stored_o)
);
`default_nettype wire
